>>> hw/rtl/stochastic_universal_sampler_assert.svh
// Assertion macros used by the sampler top level.
`ifndef STOCHASTIC_UNIVERSAL_SAMPLER_ASSERT_SVH
`define STOCHASTIC_UNIVERSAL_SAMPLER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define SUS_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sampler check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define SUS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sampler check failed");

`endif

>>> hw/rtl/sus_pkg.sv
// Shared constants and controller/datapath interface types of the sampler.
package sus_pkg;

	localparam int CHOSEN_W          = 6;
	localparam int WEIGHT_IN_W       = 16;
	localparam int PICK_W            = 8;
	localparam int RAND_W            = 16;
	localparam int POP_MAX_DEF       = 64;
	localparam int WEIGHT_BITS_DEF   = 16;
	localparam int FRACTION_BITS_DEF = 16;

	typedef struct packed {
		logic load;
		logic start;
		logic div_step;
		logic mul_step;
		logic walk_init;
		logic walk_step;
		logic fin;
	} sus_cmd_t;

	typedef struct packed {
		logic n_zero;
		logic walk_end;
		logic out_free;
	} sus_sts_t;

endpackage

>>> hw/rtl/sus_ctrl.sv
// Sequencing state machine of the sampler: load, divide, multiply, set up, walk, finish.
module sus_ctrl #(
	parameter int DIV_W = 39
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             last_weight,
	input  sus_pkg::sus_sts_t sts,
	output logic             in_ready,
	output sus_pkg::sus_cmd_t cmd
);

	localparam int STEP_W = $clog2(DIV_W + 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_MUL,
		ST_PRE,
		ST_WALK,
		ST_FIN
	} state_t;

	state_t            state_q;
	logic [STEP_W-1:0] step_q;
	logic              accept;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;

	always_comb begin
		cmd           = '0;
		cmd.load      = accept;
		cmd.start     = accept && last_weight;
		cmd.div_step  = (state_q == ST_DIV);
		cmd.mul_step  = (state_q == ST_MUL);
		cmd.walk_init = (state_q == ST_PRE);
		cmd.walk_step = (state_q == ST_WALK);
		cmd.fin       = (state_q == ST_FIN);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					step_q <= '0;
					if (accept && last_weight) begin
						state_q <= sts.n_zero ? ST_FIN : ST_DIV;
					end
				end
				ST_DIV: begin
					if (step_q == STEP_W'(DIV_W - 1)) begin
						step_q  <= '0;
						state_q <= ST_MUL;
					end else begin
						step_q <= step_q + STEP_W'(1);
					end
				end
				ST_MUL: begin
					if (step_q == STEP_W'(sus_pkg::RAND_W - 1)) begin
						step_q  <= '0;
						state_q <= ST_PRE;
					end else begin
						step_q <= step_q + STEP_W'(1);
					end
				end
				ST_PRE: state_q <= ST_WALK;
				ST_WALK: begin
					if (sts.walk_end) state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (sts.out_free) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

>>> hw/rtl/sus_dp.sv
// Sampler datapath: weight memory, total, serial divider and multiplier, pointer walk.
module sus_dp #(
	parameter int POP_MAX       = sus_pkg::POP_MAX_DEF,
	parameter int WEIGHT_BITS   = sus_pkg::WEIGHT_BITS_DEF,
	parameter int FRACTION_BITS = sus_pkg::FRACTION_BITS_DEF,
	parameter int DIV_W         = 39
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  sus_pkg::sus_cmd_t            cmd,
	output sus_pkg::sus_sts_t            sts,
	input  logic [sus_pkg::WEIGHT_IN_W-1:0] weight,
	input  logic [sus_pkg::PICK_W-1:0]   pick_count,
	input  logic [sus_pkg::RAND_W-1:0]   rand_fraction,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [sus_pkg::CHOSEN_W-1:0] chosen_index,
	output logic                         last_result,
	output logic                         nothing_chosen
);

	localparam int IDX_W = (POP_MAX > 1) ? $clog2(POP_MAX) : 1;
	localparam int CNT_W = $clog2(POP_MAX + 1);
	localparam int TOT_W = DIV_W - FRACTION_BITS;
	localparam int PW    = sus_pkg::PICK_W;

	logic [WEIGHT_BITS-1:0] mem [POP_MAX];
	logic [WEIGHT_BITS-1:0] rd_q;
	logic [IDX_W-1:0]       rd_addr;

	logic [CNT_W-1:0]  cnt_q;
	logic [TOT_W-1:0]  total_q;
	logic [PW-1:0]     n_q;
	logic [sus_pkg::RAND_W-1:0] r_q;
	logic [PW-1:0]     rem_q;
	logic [DIV_W-1:0]  quo_q;
	logic [DIV_W:0]    acc_q;
	logic [DIV_W:0]    ptr_q;
	logic [DIV_W-1:0]  sum_q;
	logic [PW-1:0]     j_q;
	logic [IDX_W-1:0]  idx_q;
	logic [IDX_W-1:0]  prev_q;
	logic              have_prev_q;
	logic              out_valid_q;
	logic [sus_pkg::CHOSEN_W-1:0] out_idx_q;
	logic              out_last_q;
	logic              out_none_q;

	logic [WEIGHT_BITS-1:0] w_in;
	logic              store_ok;
	logic [TOT_W-1:0]  tot_new;
	logic [PW:0]       div_t;
	logic [PW:0]       div_diff;
	logic              div_ge;
	logic [DIV_W+1:0]  mul_sum;
	logic              j_done, below, more, need_push, out_free;
	logic              advance, hit, take, walk_push, fin_push;

	assign w_in     = WEIGHT_BITS'(weight);
	assign store_ok = cnt_q < CNT_W'(POP_MAX);
	assign tot_new  = store_ok ? total_q + TOT_W'(w_in) : total_q;

	// One quotient bit per step, dividend shifted in from the top of quo_q.
	assign div_t    = {rem_q, quo_q[DIV_W-1]};
	assign div_ge   = div_t >= {1'b0, n_q};
	assign div_diff = div_t - {1'b0, n_q};

	// Shift-add over the random fraction, LSB first, halving each step.
	assign mul_sum = (DIV_W+2)'(acc_q) + (r_q[0] ? (DIV_W+2)'(quo_q) : '0);

	assign out_free  = !out_valid_q || out_ready;
	assign j_done    = (j_q == n_q);
	assign below     = {1'b0, sum_q} < ptr_q;
	assign more      = (CNT_W'(idx_q) + CNT_W'(1)) < cnt_q;
	assign need_push = have_prev_q && (prev_q != idx_q);
	assign advance   = cmd.walk_step && !j_done && below && more;
	assign hit       = cmd.walk_step && !j_done && !below;
	assign take      = hit && (!need_push || out_free);
	assign walk_push = hit && need_push && out_free;
	assign fin_push  = cmd.fin && out_free;

	assign sts.n_zero   = (pick_count == '0);
	assign sts.walk_end = j_done || (below && !more);
	assign sts.out_free = out_free;

	// Address for next cycle's registered read: the entry after idx during the walk, else entry 0.
	always_comb begin
		if (cmd.walk_init) rd_addr = IDX_W'(1);
		else if (advance) rd_addr = idx_q + IDX_W'(2);
		else if (cmd.walk_step) rd_addr = idx_q + IDX_W'(1);
		else rd_addr = '0;
	end

	always_ff @(posedge clk) begin
		if (cmd.load && store_ok) mem[cnt_q[IDX_W-1:0]] <= w_in;
		rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			n_q   <= pick_count;
			r_q   <= rand_fraction;
			rem_q <= '0;
			quo_q <= DIV_W'(tot_new) << FRACTION_BITS;
			acc_q <= '0;
		end
		if (cmd.div_step) begin
			rem_q <= div_ge ? div_diff[PW-1:0] : div_t[PW-1:0];
			quo_q <= {quo_q[DIV_W-2:0], div_ge};
		end
		if (cmd.mul_step) begin
			acc_q <= mul_sum[DIV_W+1:1];
			r_q   <= r_q >> 1;
		end
		if (cmd.walk_init) begin
			ptr_q <= acc_q;
			sum_q <= DIV_W'(rd_q) << FRACTION_BITS;
			j_q   <= '0;
			idx_q <= '0;
		end
		if (advance) begin
			idx_q <= idx_q + IDX_W'(1);
			sum_q <= sum_q + (DIV_W'(rd_q) << FRACTION_BITS);
		end
		if (take) begin
			j_q    <= j_q + PW'(1);
			ptr_q  <= ptr_q + (DIV_W+1)'(quo_q);
		end
		if (cmd.start) prev_q <= '0;
		else if (take) prev_q <= idx_q;
		if (walk_push || fin_push) begin
			out_idx_q  <= sus_pkg::CHOSEN_W'(prev_q);
			out_last_q <= fin_push;
			out_none_q <= fin_push && !have_prev_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			total_q     <= '0;
			have_prev_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (fin_push) begin
				cnt_q   <= '0;
				total_q <= '0;
			end else if (cmd.load && store_ok) begin
				cnt_q   <= cnt_q + CNT_W'(1);
				total_q <= tot_new;
			end
			if (cmd.start) have_prev_q <= 1'b0;
			else if (take) have_prev_q <= 1'b1;
			if (walk_push || fin_push) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	assign out_valid      = out_valid_q;
	assign chosen_index   = out_idx_q;
	assign last_result    = out_last_q;
	assign nothing_chosen = out_none_q;

endmodule

>>> hw/rtl/stochastic_universal_sampler.sv
// Stochastic universal sampler top level: controller plus datapath.
// Weights enter one beat per cycle while the sampler is idle and are stored in
// order (beyond POP_MAX they are dropped) while their total is kept. The beat
// with last_weight set also carries pick_count n and rand_fraction r and
// starts a pass: the spacing p = (total << FRACTION_BITS) / n comes from a
// restoring divider, one quotient bit a cycle; start = r*p >> 16 comes from a
// shift-add multiplier; a setup state follows. The walk then steps once per
// pointer and once per stored weight it passes, stalling while a chosen index
// waits on a full output, and a finish state hands out the final beat. Chosen
// indices leave in ascending order, each once, the last one flagged with
// last_result; with n = 0 a single beat with nothing_chosen set is returned.
// The input is not ready during a pass; the output register lets a weight
// beat be taken while a result waits.
module stochastic_universal_sampler #(
	parameter int POP_MAX       = sus_pkg::POP_MAX_DEF,
	parameter int WEIGHT_BITS   = sus_pkg::WEIGHT_BITS_DEF,
	parameter int FRACTION_BITS = sus_pkg::FRACTION_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [sus_pkg::WEIGHT_IN_W-1:0] weight,
	input  logic                            last_weight,
	input  logic [sus_pkg::PICK_W-1:0]      pick_count,
	input  logic [sus_pkg::RAND_W-1:0]      rand_fraction,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [sus_pkg::CHOSEN_W-1:0]    chosen_index,
	output logic                            last_result,
	output logic                            nothing_chosen
);

	`include "stochastic_universal_sampler_assert.svh"

	// Dividend width: total (weights plus count headroom) scaled by the fraction.
	localparam int DIV_W = WEIGHT_BITS + $clog2(POP_MAX + 1) + FRACTION_BITS;

	sus_pkg::sus_cmd_t cmd;
	sus_pkg::sus_sts_t sts;

	sus_ctrl #(
		.DIV_W(DIV_W)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.last_weight(last_weight),
		.sts        (sts),
		.in_ready   (in_ready),
		.cmd        (cmd)
	);

	sus_dp #(
		.POP_MAX      (POP_MAX),
		.WEIGHT_BITS  (WEIGHT_BITS),
		.FRACTION_BITS(FRACTION_BITS),
		.DIV_W        (DIV_W)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.weight        (weight),
		.pick_count    (pick_count),
		.rand_fraction (rand_fraction),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.chosen_index  (chosen_index),
		.last_result   (last_result),
		.nothing_chosen(nothing_chosen)
	);

	// A pass in its divide or walk steps never takes new weights.
	`SUS_ASSERT_NOW(a_walk_blocks_input, cmd.walk_step || cmd.div_step, !in_ready)
	// A last weight always starts a pass: input closes on the next cycle.
	`SUS_ASSERT_NEXT(a_last_starts_pass, in_valid && in_ready && last_weight, !in_ready)
	// An empty result only ever closes a pass and carries index zero.
	`SUS_ASSERT_NOW(a_empty_result, out_valid && nothing_chosen,
		last_result && (chosen_index == '0))

endmodule
